FILE: src/tpzs_pkg.sv
`default_nettype none
package tpzs_pkg;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SIN_MUL,
		ST_SIN_WB,
		ST_UOP,
		ST_UOP_WB,
		ST_DIV,
		ST_PX_MUL,
		ST_PX_WB,
		ST_PY_MUL,
		ST_PY_WB,
		ST_ADDR_MUL,
		ST_ADDR_WB,
		ST_MEM_RD,
		ST_MEM_CMP,
		ST_COL_MUL,
		ST_COL_WB,
		ST_RD_WAIT
	} state_t;

	typedef enum logic [1:0] {
		UOP_MUL,
		UOP_ADD,
		UOP_SUB,
		UOP_ADDH
	} uop_kind_t;

	typedef struct packed {
		uop_kind_t  kind;
		logic [3:0] dst;
		logic [3:0] a;
		logic [3:0] b;
	} uop_t;

	localparam logic OP_PLOT = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register file slots: trig values first, then temporaries
	localparam logic [3:0] R_C   = 4'd0;
	localparam logic [3:0] R_L   = 4'd1;
	localparam logic [3:0] R_F   = 4'd2;
	localparam logic [3:0] R_D   = 4'd3;
	localparam logic [3:0] R_E   = 4'd4;
	localparam logic [3:0] R_G   = 4'd5;
	localparam logic [3:0] R_N   = 4'd6;
	localparam logic [3:0] R_M   = 4'd7;
	localparam logic [3:0] R_H   = 4'd8;
	localparam logic [3:0] R_CH  = 4'd9;
	localparam logic [3:0] R_LH  = 4'd10;
	localparam logic [3:0] R_CD  = 4'd11;
	localparam logic [3:0] R_DEN = 4'd12;
	localparam logic [3:0] R_FG  = 4'd13;
	localparam logic [3:0] R_T   = 4'd14;
	localparam logic [3:0] R_FE  = 4'd15;
	localparam logic [3:0] R_Q   = R_H;
	localparam logic [3:0] R_P   = R_CH;
	localparam logic [3:0] R_LUM = R_LH;

	localparam int UOP_COUNT = 25;
	localparam int DIV_STEPS = 31;

	localparam int SIN_K  = 1160;
	localparam int SIN_W0 = 10512;
	localparam int SIN_V0 = 25736;
	localparam int DEN_BIAS = 81920;
	localparam int X_ORIGIN = 40;
	localparam int X_SCALE  = 30;
	localparam int Y_ORIGIN = 12;
	localparam int Y_SCALE  = 15;

	localparam logic [6:0] CHAR_SPACE   = 7'd32;
	localparam logic [6:0] CHAR_NEWLINE = 7'd10;

	function automatic uop_t uop_rom(logic [4:0] pc);
		uop_t u;
		u = '{UOP_MUL, R_C, R_C, R_C};
		case (pc)
			5'd0:  u = '{UOP_ADDH, R_H, R_D, R_D};
			5'd1:  u = '{UOP_MUL, R_CH, R_C, R_H};
			5'd2:  u = '{UOP_MUL, R_LH, R_L, R_H};
			5'd3:  u = '{UOP_MUL, R_CD, R_C, R_D};
			5'd4:  u = '{UOP_MUL, R_DEN, R_CH, R_E};
			5'd5:  u = '{UOP_MUL, R_FG, R_F, R_G};
			5'd6:  u = '{UOP_ADD, R_DEN, R_DEN, R_FG};
			5'd7:  u = '{UOP_MUL, R_T, R_CH, R_G};
			5'd8:  u = '{UOP_MUL, R_FE, R_F, R_E};
			5'd9:  u = '{UOP_SUB, R_T, R_T, R_FE};
			5'd10: u = '{UOP_MUL, R_P, R_LH, R_M};
			5'd11: u = '{UOP_MUL, R_H, R_T, R_N};
			5'd12: u = '{UOP_SUB, R_P, R_P, R_H};
			5'd13: u = '{UOP_MUL, R_H, R_LH, R_N};
			5'd14: u = '{UOP_MUL, R_C, R_T, R_M};
			5'd15: u = '{UOP_ADD, R_Q, R_H, R_C};
			5'd16: u = '{UOP_MUL, R_LH, R_CD, R_G};
			5'd17: u = '{UOP_SUB, R_LH, R_FE, R_LH};
			5'd18: u = '{UOP_MUL, R_LH, R_LH, R_M};
			5'd19: u = '{UOP_MUL, R_T, R_CD, R_E};
			5'd20: u = '{UOP_SUB, R_LH, R_LH, R_T};
			5'd21: u = '{UOP_SUB, R_LH, R_LH, R_FG};
			5'd22: u = '{UOP_MUL, R_T, R_L, R_D};
			5'd23: u = '{UOP_MUL, R_T, R_T, R_N};
			5'd24: u = '{UOP_ADD, R_LUM, R_LH, R_T};
			default: u = '{UOP_MUL, R_C, R_C, R_C};
		endcase
		return u;
	endfunction

	function automatic logic [6:0] shade_char(logic [3:0] idx);
		logic [6:0] ch;
		case (idx)
			4'd0:  ch = 7'h2E;
			4'd1:  ch = 7'h2C;
			4'd2:  ch = 7'h2D;
			4'd3:  ch = 7'h7E;
			4'd4:  ch = 7'h3A;
			4'd5:  ch = 7'h3B;
			4'd6:  ch = 7'h3D;
			4'd7:  ch = 7'h21;
			4'd8:  ch = 7'h2A;
			4'd9:  ch = 7'h23;
			4'd10: ch = 7'h24;
			default: ch = 7'h40;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: src/torus_point_zbuffer_shader_unit.sv
`default_nettype none
// Torus point z-buffer shader.
// Request channel (req_valid/req_ready) carries one item: a plot of one torus
// surface point (four angle phases) or a read-and-clear of one grid cell.
// Response channel (rsp_valid/rsp_ready) returns one character per read;
// a plot returns nothing.
// One item is in flight at a time; req_ready is high only when idle.
// A plot runs 32 multiplies of the shared 18x18 multiplier for the eight
// sines, 16 multiplies and 9 adds for the torus terms, a bit-serial divide
// for the inverse depth, then the projection, address and a read-compare-write
// of the grid; a point that is off the grid ends after the address step.
// A read passes through a column multiply before its character is registered;
// one multiply by the reciprocal of GRID_COLS finds column zero.
// After reset the block sweeps the grid memory once, one cell per cycle
// (all GRID_COLS*GRID_ROWS cells, 1760 by default), writing a space at depth 0;
// no request is taken during the sweep.
// The result sits in an output register; while the receiver stalls a read
// is held at its final step, and a plot still completes.
module torus_point_zbuffer_shader_unit #(
	parameter int GRID_COLS  = 80,
	parameter int GRID_ROWS  = 22,
	parameter int PHASE_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  operation,
	input  wire logic [PHASE_BITS-1:0] tube_phase,
	input  wire logic [PHASE_BITS-1:0] ring_phase,
	input  wire logic [PHASE_BITS-1:0] tilt_phase,
	input  wire logic [PHASE_BITS-1:0] spin_phase,
	input  wire logic [10:0]           cell_index,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic [6:0]                 char_code
);

	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int DW    = 24;
	// ceil(2^19 / GRID_COLS); exact for any 11-bit index
	localparam int COL_RECIP = (2**19 + GRID_COLS - 1) / GRID_COLS;

	tpzs_pkg::state_t state_q, state_d;

	logic signed [17:0] r_q [16];
	logic [4:0]         pc_q;
	logic [2:0]         ang_q;
	logic [1:0]         sstep_q;
	logic [14:0]        sin_s_q;
	logic [13:0]        sin_w_q;
	logic [14:0]        sin_v_q;
	logic signed [35:0] prod_q;
	logic signed [17:0] mul_a, mul_b;

	logic [PHASE_BITS-1:0] tube_q, ring_q, tilt_q, spin_q;

	logic [30:0] div_num_q;
	logic [19:0] div_rem_q;
	logic [18:0] div_den_q;
	logic [4:0]  div_cnt_q;
	logic [19:0] rem_sh;
	logic        rem_ge;

	logic               op_q;
	logic               range_ok_q;
	logic               col0_q;
	logic [16:0]        dq_q;
	logic signed [15:0] x_q, y_q;
	logic [AW-1:0]      addr_q;
	logic [DW-1:0]      mem_q [CELLS];
	logic [DW-1:0]      rd_q;
	logic               mem_we;
	logic [DW-1:0]      mem_wd;
	logic               out_valid_q;
	logic [6:0]         out_char_q;
	logic               out_load;
	logic [6:0]         out_char_d;

	tpzs_pkg::uop_t     uop;
	logic               uop_done;
	logic signed [35:0] mul_round;
	logic signed [17:0] mul_q14;
	logic [21:0]        prod_sh;

	logic [PHASE_BITS-1:0] sin_phase;
	logic [15:0]           u16;
	logic [14:0]           t15;
	logic [14:0]           sin_r;

	logic signed [41:0] proj_big, proj_adj;
	logic signed [15:0] proj_val;
	logic               in_grid;

	logic signed [17:0] lum_adj;
	logic signed [17:0] lum_div;
	logic [3:0]         nidx;

	assign uop = tpzs_pkg::uop_rom(pc_q);

	// sine argument for the current angle slot; odd slots are cosines
	always_comb begin
		case (ang_q[2:1])
			2'd0:    sin_phase = tube_q;
			2'd1:    sin_phase = ring_q;
			2'd2:    sin_phase = tilt_q;
			default: sin_phase = spin_q;
		endcase
		u16 = (16'(sin_phase) << (16 - PHASE_BITS)) + (ang_q[0] ? 16'h4000 : 16'h0000);
		t15 = u16[14] ? 15'(15'd16384 - {1'b0, u16[13:0]}) : {1'b0, u16[13:0]};
	end

	assign prod_sh   = prod_q[35:14];
	assign sin_r     = 15'(prod_sh);
	assign mul_round = prod_q + (prod_q[35] ? 36'sd16383 : 36'sd0);
	assign mul_q14   = 18'(mul_round >>> 14);

	assign rem_sh = {div_rem_q[18:0], div_num_q[30]};
	assign rem_ge = rem_sh >= {1'b0, div_den_q};

	// projection: origin + scale*D*coord, divided by 2^30 toward zero
	always_comb begin
		if (state_q == tpzs_pkg::ST_PX_WB) begin
			proj_big = 42'(prod_q) * 42'(tpzs_pkg::X_SCALE)
				+ (42'(tpzs_pkg::X_ORIGIN) <<< 30);
		end else begin
			proj_big = 42'(prod_q) * 42'(tpzs_pkg::Y_SCALE)
				+ (42'(tpzs_pkg::Y_ORIGIN) <<< 30);
		end
		proj_adj = proj_big + (proj_big[41] ? 42'sd1073741823 : 42'sd0);
		proj_val = 16'(proj_adj >>> 30);
	end

	assign in_grid = !x_q[15] && !y_q[15]
		&& (x_q < 16'(GRID_COLS)) && (y_q < 16'(GRID_ROWS));

	// luminance index: 8*L/16384 toward zero, clamped to the ramp
	always_comb begin
		lum_adj = r_q[tpzs_pkg::R_LUM] + (r_q[tpzs_pkg::R_LUM][17] ? 18'sd2047 : 18'sd0);
		lum_div = lum_adj >>> 11;
		if (lum_div[17]) begin
			nidx = 4'd0;
		end else if (lum_div > 18'sd11) begin
			nidx = 4'd11;
		end else begin
			nidx = 4'(lum_div);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpzs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_a      = '0;
		mul_b      = '0;
		mem_we     = 1'b0;
		mem_wd     = {17'd0, tpzs_pkg::CHAR_SPACE};
		out_load   = 1'b0;
		out_char_d = tpzs_pkg::CHAR_SPACE;
		uop_done   = 1'b0;
		req_ready  = 1'b0;
		case (state_q)
			tpzs_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == AW'(CELLS - 1)) begin
					state_d = tpzs_pkg::ST_IDLE;
				end
			end
			tpzs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (operation == tpzs_pkg::OP_READ) ? tpzs_pkg::ST_COL_MUL
						: tpzs_pkg::ST_SIN_MUL;
				end
			end
			tpzs_pkg::ST_SIN_MUL: begin
				case (sstep_q)
					2'd0: begin
						mul_a = 18'(t15);
						mul_b = 18'(t15);
					end
					2'd1: begin
						mul_a = 18'(tpzs_pkg::SIN_K);
						mul_b = 18'(sin_s_q);
					end
					2'd2: begin
						mul_a = 18'(sin_s_q);
						mul_b = 18'(sin_w_q);
					end
					default: begin
						mul_a = 18'(t15);
						mul_b = 18'(sin_v_q);
					end
				endcase
				state_d = tpzs_pkg::ST_SIN_WB;
			end
			tpzs_pkg::ST_SIN_WB: begin
				if (sstep_q == 2'd3 && ang_q == 3'd7) begin
					state_d = tpzs_pkg::ST_UOP;
				end else begin
					state_d = tpzs_pkg::ST_SIN_MUL;
				end
			end
			tpzs_pkg::ST_UOP: begin
				mul_a = r_q[uop.a];
				mul_b = r_q[uop.b];
				if (uop.kind == tpzs_pkg::UOP_MUL) begin
					state_d = tpzs_pkg::ST_UOP_WB;
				end else begin
					uop_done = 1'b1;
				end
			end
			tpzs_pkg::ST_UOP_WB: begin
				uop_done = 1'b1;
				state_d  = tpzs_pkg::ST_UOP;
			end
			tpzs_pkg::ST_DIV: begin
				if (div_cnt_q == 5'(tpzs_pkg::DIV_STEPS - 1)) begin
					state_d = (op_q == tpzs_pkg::OP_READ) ? tpzs_pkg::ST_RD_WAIT
						: tpzs_pkg::ST_PX_MUL;
				end
			end
			tpzs_pkg::ST_PX_MUL: begin
				mul_a   = 18'(dq_q);
				mul_b   = r_q[tpzs_pkg::R_P];
				state_d = tpzs_pkg::ST_PX_WB;
			end
			tpzs_pkg::ST_PX_WB: begin
				state_d = tpzs_pkg::ST_PY_MUL;
			end
			tpzs_pkg::ST_PY_MUL: begin
				mul_a   = 18'(dq_q);
				mul_b   = r_q[tpzs_pkg::R_Q];
				state_d = tpzs_pkg::ST_PY_WB;
			end
			tpzs_pkg::ST_PY_WB: begin
				state_d = tpzs_pkg::ST_ADDR_MUL;
			end
			tpzs_pkg::ST_ADDR_MUL: begin
				mul_a   = 18'(y_q);
				mul_b   = 18'(GRID_COLS);
				state_d = in_grid ? tpzs_pkg::ST_ADDR_WB : tpzs_pkg::ST_IDLE;
			end
			tpzs_pkg::ST_ADDR_WB: begin
				state_d = tpzs_pkg::ST_MEM_RD;
			end
			tpzs_pkg::ST_MEM_RD: begin
				state_d = tpzs_pkg::ST_MEM_CMP;
			end
			tpzs_pkg::ST_MEM_CMP: begin
				// keep the nearer point only
				if (dq_q > rd_q[DW-1:7]) begin
					mem_we = 1'b1;
					mem_wd = {dq_q, tpzs_pkg::shade_char(nidx)};
				end
				state_d = tpzs_pkg::ST_IDLE;
			end
			tpzs_pkg::ST_COL_MUL: begin
				mul_a   = 18'(addr_q);
				mul_b   = 18'(COL_RECIP);
				state_d = tpzs_pkg::ST_COL_WB;
			end
			tpzs_pkg::ST_COL_WB: begin
				state_d = tpzs_pkg::ST_RD_WAIT;
			end
			tpzs_pkg::ST_RD_WAIT: begin
				if (!range_ok_q) begin
					out_char_d = tpzs_pkg::CHAR_SPACE;
				end else if (col0_q) begin
					out_char_d = tpzs_pkg::CHAR_NEWLINE;
				end else begin
					out_char_d = rd_q[6:0];
				end
				// hold until the output register is free
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					mem_we   = range_ok_q;
					state_d  = tpzs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpzs_pkg::ST_IDLE;
			end
		endcase
		if (uop_done && pc_q == 5'(tpzs_pkg::UOP_COUNT - 1)) begin
			state_d = tpzs_pkg::ST_DIV;
		end
	end

	// sequencer counters, divider step count, request fields and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			pc_q        <= '0;
			ang_q       <= '0;
			sstep_q     <= '0;
			div_cnt_q   <= '0;
			op_q        <= tpzs_pkg::OP_PLOT;
			range_ok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				tpzs_pkg::ST_CLEAR: begin
					addr_q <= addr_q + AW'(1);
				end
				tpzs_pkg::ST_IDLE: begin
					if (req_valid) begin
						op_q       <= operation;
						addr_q     <= AW'(cell_index);
						range_ok_q <= 17'(cell_index) < 17'(CELLS);
						ang_q      <= '0;
						sstep_q    <= '0;
						pc_q       <= '0;
						div_cnt_q  <= '0;
					end
				end
				tpzs_pkg::ST_SIN_WB: begin
					sstep_q <= sstep_q + 2'd1;
					if (sstep_q == 2'd3) begin
						ang_q <= ang_q + 3'd1;
					end
				end
				tpzs_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
				end
				tpzs_pkg::ST_ADDR_WB: begin
					addr_q <= AW'(prod_q + 36'(x_q));
				end
				default: begin
				end
			endcase
			if (uop_done) begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (out_load) begin
			out_char_q <= out_char_d;
		end
		case (state_q)
			tpzs_pkg::ST_IDLE: begin
				tube_q <= tube_phase;
				ring_q <= ring_phase;
				tilt_q <= tilt_phase;
				spin_q <= spin_phase;
			end
			tpzs_pkg::ST_SIN_WB: begin
				case (sstep_q)
					2'd0: sin_s_q <= 15'(prod_sh);
					2'd1: sin_w_q <= 14'(tpzs_pkg::SIN_W0) - 14'(prod_sh);
					2'd2: sin_v_q <= 15'(tpzs_pkg::SIN_V0) - 15'(prod_sh);
					default: begin
						r_q[{1'b0, ang_q}] <= u16[15] ? -18'(sin_r) : 18'(sin_r);
					end
				endcase
			end
			tpzs_pkg::ST_UOP: begin
				case (uop.kind)
					tpzs_pkg::UOP_ADD:  r_q[uop.dst] <= r_q[uop.a] + r_q[uop.b];
					tpzs_pkg::UOP_SUB:  r_q[uop.dst] <= r_q[uop.a] - r_q[uop.b];
					tpzs_pkg::UOP_ADDH: r_q[uop.dst] <= r_q[uop.a] + 18'sd32768;
					default: begin
					end
				endcase
			end
			tpzs_pkg::ST_UOP_WB: begin
				r_q[uop.dst] <= mul_q14;
			end
			tpzs_pkg::ST_DIV: begin
				if (rem_ge) begin
					div_rem_q <= rem_sh - {1'b0, div_den_q};
				end else begin
					div_rem_q <= rem_sh;
				end
				div_num_q <= {div_num_q[29:0], rem_ge};
				dq_q      <= {div_num_q[15:0], rem_ge};
			end
			tpzs_pkg::ST_PX_WB: begin
				x_q <= proj_val;
			end
			tpzs_pkg::ST_PY_WB: begin
				y_q <= proj_val;
			end
			tpzs_pkg::ST_COL_WB: begin
				// a multiple of GRID_COLS leaves a fraction below the reciprocal
				col0_q <= prod_q[18:0] < 19'(COL_RECIP);
			end
			default: begin
			end
		endcase
		// load the depth divide: 2^30 / (den + 5.0)
		if (uop_done && pc_q == 5'(tpzs_pkg::UOP_COUNT - 1)) begin
			div_num_q <= 31'(1) << 30;
			div_rem_q <= '0;
			div_den_q <= 19'(20'(r_q[tpzs_pkg::R_DEN]) + 20'(tpzs_pkg::DEN_BIAS));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= mem_wd;
		end
		rd_q <= mem_q[addr_q];
	end

	assign rsp_valid = out_valid_q;
	assign char_code = out_char_q;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tpzs_pkg::ST_CLEAR |-> !req_ready)
		else $error("request taken during grid clear");

	a_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == tpzs_pkg::ST_RD_WAIT)
		else $error("response raised outside read step");

	a_plot_nearer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpzs_pkg::ST_MEM_CMP && mem_we) |-> dq_q > rd_q[DW-1:7])
		else $error("plot wrote a farther depth");

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tpzs_pkg::ST_DIV |-> div_cnt_q < 5'(tpzs_pkg::DIV_STEPS))
		else $error("divider ran past its step count");

endmodule
`default_nettype wire

FILE: dv/torus_point_zbuffer_shader_unit_tb.sv
`default_nettype none
module torus_point_zbuffer_shader_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS = 80;
	localparam int ROWS = 22;
	localparam int CELLS = COLS * ROWS;
	localparam longint CYCLE_LIMIT = 2000000;

	class grid_scoreboard;
		logic [16:0] depth_q[CELLS];
		logic [6:0]  shade_q[CELLS];
		logic [6:0]  pending_chars[$];
		int          errors;

		function void clear_grid();
			for (int k = 0; k < CELLS; k++) begin
				depth_q[k] = '0;
				shade_q[k] = tpzs_pkg::CHAR_SPACE;
			end
			errors = 0;
		endfunction

		function longint qsin(int unsigned u);
			int unsigned q, x, t, s, w, v, r;
			u = u & 32'hFFFF;
			q = u >> 14;
			x = u & 32'h3FFF;
			t = q[0] ? 16384 - x : x;
			s = (t * t) >> 14;
			w = 10512 - ((1160 * s) >> 14);
			v = 25736 - ((s * w) >> 14);
			r = (t * v) >> 14;
			return (q >= 2) ? -longint'(r) : longint'(r);
		endfunction

		function longint qm(longint a, longint b);
			return (a * b) / 16384;
		endfunction

		function logic [6:0] glyph(int idx);
			case (idx)
				0: return 7'h2E;  1: return 7'h2C;  2: return 7'h2D;  3: return 7'h7E;
				4: return 7'h3A;  5: return 7'h3B;  6: return 7'h3D;  7: return 7'h21;
				8: return 7'h2A;  9: return 7'h23;  10: return 7'h24;
				default: return 7'h40;
			endcase
		endfunction

		function void note_request(logic op, logic [11:0] tp, logic [11:0] rp,
				logic [11:0] ap, logic [11:0] bp, logic [10:0] idx);
			longint c, l, f, d, e, g, n, m, h, ch, lh, cd, den, dq, tt, p, q, x, y, lum, ni;
			int o;
			if (op == tpzs_pkg::OP_READ) begin
				if (idx < CELLS) begin
					pending_chars.push_back(idx % COLS == 0 ? tpzs_pkg::CHAR_NEWLINE
						: shade_q[idx]);
					depth_q[idx] = '0;
					shade_q[idx] = tpzs_pkg::CHAR_SPACE;
				end else
					pending_chars.push_back(tpzs_pkg::CHAR_SPACE);
				return;
			end
			c = qsin(tp << 4); l = qsin((tp << 4) + 16384);
			f = qsin(rp << 4); d = qsin((rp << 4) + 16384);
			e = qsin(ap << 4); g = qsin((ap << 4) + 16384);
			n = qsin(bp << 4); m = qsin((bp << 4) + 16384);
			h = d + 32768;
			ch = qm(c, h); lh = qm(l, h); cd = qm(c, d);
			den = qm(ch, e) + qm(f, g) + 81920;
			if (den < 1) den = 1;
			dq = (longint'(1) << 30) / den;
			tt = qm(ch, g) - qm(f, e);
			p = qm(lh, m) - qm(tt, n);
			q = qm(lh, n) + qm(tt, m);
			x = (40 * (longint'(1) << 30) + 30 * dq * p) / (longint'(1) << 30);
			y = (12 * (longint'(1) << 30) + 15 * dq * q) / (longint'(1) << 30);
			lum = qm(qm(f, e) - qm(cd, g), m) - qm(cd, e) - qm(f, g) + qm(qm(l, d), n);
			ni = (8 * lum) / 16384;
			if (ni < 0) ni = 0;
			if (ni > 11) ni = 11;
			if (y >= 0 && y < ROWS && x >= 0 && x < COLS) begin
				o = int'(x + COLS * y);
				if (dq > longint'(depth_q[o])) begin
					depth_q[o] = dq[16:0];
					shade_q[o] = glyph(int'(ni));
				end
			end
		endfunction

		function void check_char(logic [6:0] got);
			if (pending_chars.size() == 0) begin
				$error("char_code: no request waiting, actual %0d", got);
				errors++;
				return;
			end
			if (got !== pending_chars[0]) begin
				$error("char_code: expected %0d actual %0d", pending_chars[0], got);
				errors++;
			end
			void'(pending_chars.pop_front());
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic operation = 1'b0;
	logic [11:0] tube_phase = '0, ring_phase = '0, tilt_phase = '0, spin_phase = '0;
	logic [10:0] cell_index = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [6:0] char_code;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;
	longint cycles = 0;

	grid_scoreboard sb = new();

	torus_point_zbuffer_shader_unit i_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.operation(operation), .tube_phase(tube_phase), .ring_phase(ring_phase),
		.tilt_phase(tilt_phase), .spin_phase(spin_phase), .cell_index(cell_index),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .char_code(char_code)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (rsp_valid && rsp_ready)
			sb.check_char(char_code);
	end

	// receiver: random stall pattern, plus one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			mode = int'((cycles / 3000) % 3);
			if (hold_off)
				rsp_ready <= 1'b0;
			else if (mode == 0)
				rsp_ready <= 1'b1;
			else if (mode == 1)
				rsp_ready <= ($urandom_range(0, 3) != 0);
			else
				rsp_ready <= ($urandom_range(0, 9) < 3);
		end
	end

	task automatic send(logic op, logic [11:0] tp, logic [11:0] rp, logic [11:0] ap,
			logic [11:0] bp, logic [10:0] idx);
		operation <= op; tube_phase <= tp; ring_phase <= rp;
		tilt_phase <= ap; spin_phase <= bp; cell_index <= idx;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(op, tp, rp, ap, bp, idx);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		req_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	task automatic send_plot_random();
		send(tpzs_pkg::OP_PLOT, 12'($urandom), 12'($urandom), 12'($urandom),
			12'($urandom), 11'($urandom));
	endtask

	task automatic send_read_random();
		logic [10:0] idx;
		idx = ($urandom_range(0, 19) == 0) ? 11'($urandom_range(CELLS, 2047))
			: 11'($urandom_range(0, CELLS - 1));
		send(tpzs_pkg::OP_READ, 12'($urandom), 12'($urandom), 12'($urandom),
			12'($urandom), idx);
	endtask

	initial begin
		int burst;
		int sent;
		sb.clear_grid();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: phase extremes, reads of corners and out of range indexes
		send(tpzs_pkg::OP_PLOT, 12'h000, 12'h000, 12'h000, 12'h000, 11'h7FF);
		send(tpzs_pkg::OP_PLOT, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 11'h000);
		send(tpzs_pkg::OP_PLOT, 12'h400, 12'h800, 12'hC00, 12'h400, 11'd5);
		send(tpzs_pkg::OP_PLOT, 12'h800, 12'h400, 12'h400, 12'hC00, 11'd5);
		send(tpzs_pkg::OP_PLOT, 12'hC00, 12'hC00, 12'h800, 12'h800, 11'd5);
		send(tpzs_pkg::OP_PLOT, 12'h000, 12'h000, 12'h000, 12'h000, 11'd0);
		send(tpzs_pkg::OP_PLOT, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 11'd0);
		send(tpzs_pkg::OP_PLOT, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 11'd0);
		send(tpzs_pkg::OP_READ, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 11'd0);
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'd1);
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'd79);
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'd80);
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'(CELLS - 1));
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'(CELLS));
		send(tpzs_pkg::OP_READ, 12'h000, 12'h000, 12'h000, 12'h000, 11'h7FF);
		sent = 15;
		// long receiver hold-off while requests keep coming
		hold_off = 1'b1;
		fork
			begin
				repeat (1500) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (6) begin
				send_read_random();
				send_plot_random();
			end
		join
		sent += 12;
		// random: mostly plots, with reads of random cells, some out of range
		while (sent < 1650) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				if ($urandom_range(0, 99) < 70)
					send_plot_random();
				else
					send_read_random();
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap();
		end
		// read back every seventh cell so stored shades are seen
		for (int k = 0; k < CELLS; k += 7) begin
			send(tpzs_pkg::OP_READ, 12'($urandom), 12'($urandom), 12'($urandom),
				12'($urandom), 11'(k));
			if ($urandom_range(0, 15) == 0) idle_gap();
		end
		req_valid <= 1'b0;
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_chars.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
src/tpzs_pkg.sv
src/torus_point_zbuffer_shader_unit.sv
dv/torus_point_zbuffer_shader_unit_tb.sv
